// ----- hdl/msw_pkg.sv -----
// Shared types and constants for the morphing world bounding sphere block.
// Used by every module in this folder.
package msw_pkg;
    localparam int unsigned CenterW = 24;
    localparam int unsigned RadiusW = 23;
    localparam int unsigned BlendW  = 17;
    localparam int unsigned RowElemW = 20;
    localparam int unsigned RowW    = 3 * RowElemW;
    localparam int unsigned ScaleW  = 20;
    localparam int unsigned OutRadW = 24;
    localparam int unsigned InDataW = 208;
    localparam int unsigned OutDataW = 96;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned BlendOne = 65536;
    localparam logic [ScaleW-1:0] ScaleUnity = ScaleW'(65536);

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROW_RIGHT = 3'd0,
        REG_ROW_UP    = 3'd1,
        REG_ROW_AT    = 3'd2,
        REG_OFFSET_X  = 3'd3,
        REG_OFFSET_Y  = 3'd4,
        REG_OFFSET_Z  = 3'd5,
        REG_RIGID     = 3'd6,
        REG_UNUSED    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [CenterW-1:0] sx;
        logic signed [CenterW-1:0] sy;
        logic signed [CenterW-1:0] sz;
        logic [RadiusW-1:0]        sr;
        logic signed [CenterW-1:0] ex;
        logic signed [CenterW-1:0] ey;
        logic signed [CenterW-1:0] ez;
        logic [RadiusW-1:0]        er;
        logic [BlendW-1:0]         blend;
        logic                      interp;
    } t_sphere_in;

    typedef struct packed {
        logic signed [CenterW-1:0] cx;
        logic signed [CenterW-1:0] cy;
        logic signed [CenterW-1:0] cz;
        logic [RadiusW-1:0]        r;
    } t_local_sphere;

    typedef struct packed {
        logic [RowW-1:0]           right;
        logic [RowW-1:0]           up;
        logic [RowW-1:0]           at;
        logic signed [CenterW-1:0] off_x;
        logic signed [CenterW-1:0] off_y;
        logic signed [CenterW-1:0] off_z;
        logic                      rigid;
        logic [ScaleW-1:0]         scale;
    } t_frame;

    function automatic logic signed [RowElemW-1:0] row_elem(input logic [RowW-1:0] row,
                                                            input int unsigned k);
        row_elem = row[k*RowElemW +: RowElemW];
    endfunction
endpackage

// ----- hdl/msw_blend.sv -----
// Two pipeline stages: blend products, then rounded blend of centre and radius.
// Depends on msw_pkg.
module msw_blend import msw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_sphere_in    i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output t_local_sphere o_item
);
    localparam int unsigned DiffW = CenterW + 1;
    localparam int unsigned ProdW = DiffW + BlendW + 1;

    logic                     r_v1, r_v2;
    logic signed [ProdW-1:0]  r_px, r_py, r_pz, r_pr;
    logic signed [CenterW-1:0] r_sx, r_sy, r_sz;
    logic [RadiusW-1:0]       r_sr;
    logic                     r_interp;
    t_local_sphere            r_out;
    logic                     rdy1, rdy2;
    logic signed [BlendW:0]   a;
    t_local_sphere            n_out;
    logic signed [ProdW-1:0]  rx, ry, rz, rr;

    assign rdy2 = !r_v2 || i_ready;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_item = r_out;

    always_comb begin
        if (i_item.blend > BlendW'(BlendOne)) begin
            a = (BlendW+1)'(BlendOne);
        end else begin
            a = {1'b0, i_item.blend};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
        if (rdy1 && i_valid) begin
            r_px <= ProdW'((DiffW'(i_item.ex) - DiffW'(i_item.sx)) * a);
            r_py <= ProdW'((DiffW'(i_item.ey) - DiffW'(i_item.sy)) * a);
            r_pz <= ProdW'((DiffW'(i_item.ez) - DiffW'(i_item.sz)) * a);
            r_pr <= ProdW'(($signed({2'b00, i_item.er}) - $signed({2'b00, i_item.sr})) * a);
            r_sx <= i_item.sx;
            r_sy <= i_item.sy;
            r_sz <= i_item.sz;
            r_sr <= i_item.sr;
            r_interp <= i_item.interp;
        end
        if (rdy2 && r_v1) r_out <= n_out;
    end

    always_comb begin
        rx = (r_px + ProdW'(32768)) >>> 16;
        ry = (r_py + ProdW'(32768)) >>> 16;
        rz = (r_pz + ProdW'(32768)) >>> 16;
        rr = (r_pr + ProdW'(32768)) >>> 16;
        if (r_interp) begin
            n_out.cx = CenterW'(rx + ProdW'(r_sx));
            n_out.cy = CenterW'(ry + ProdW'(r_sy));
            n_out.cz = CenterW'(rz + ProdW'(r_sz));
            n_out.r  = RadiusW'(rr + ProdW'($signed({1'b0, r_sr})));
        end else begin
            n_out.cx = r_sx;
            n_out.cy = r_sy;
            n_out.cz = r_sz;
            n_out.r  = r_sr;
        end
    end
endmodule

// ----- hdl/msw_xform.sv -----
// Two pipeline stages: matrix and radius products, then sum, round, offset and saturate.
// Depends on msw_pkg.
module msw_xform import msw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_local_sphere       i_item,
    input  t_frame              i_frame,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OutDataW-1:0] o_data
);
    localparam int unsigned PW = CenterW + RowElemW;
    localparam int unsigned AccW = PW + 2;
    localparam int unsigned RPW = RadiusW + ScaleW;

    logic                    r_v3, r_v4;
    logic signed [PW-1:0]    r_p [3][3];
    logic [RPW-1:0]          r_rp;
    logic [RadiusW-1:0]      r_r;
    logic                    r_rigid;
    logic [OutDataW-1:0]     r_data;
    logic                    rdy3, rdy4;
    logic signed [CenterW-1:0] c [3];
    logic [RowW-1:0]         rows [3];
    logic signed [CenterW-1:0] offs [3];
    logic [OutDataW-1:0]     n_data;

    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_v4;
    assign o_data = r_data;

    assign c[0] = i_item.cx;
    assign c[1] = i_item.cy;
    assign c[2] = i_item.cz;
    assign rows[0] = i_frame.right;
    assign rows[1] = i_frame.up;
    assign rows[2] = i_frame.at;
    assign offs[0] = i_frame.off_x;
    assign offs[1] = i_frame.off_y;
    assign offs[2] = i_frame.off_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) r_v3 <= i_valid;
            if (rdy4) r_v4 <= r_v3;
        end
        if (rdy3 && i_valid) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p[j][k] <= PW'(c[k] * row_elem(rows[k], j));
                end
            end
            r_rp <= RPW'(i_item.r) * RPW'(i_frame.scale);
            r_r <= i_item.r;
            r_rigid <= i_frame.rigid;
        end
        if (rdy4 && r_v3) r_data <= n_data;
    end

    always_comb begin
        logic signed [AccW-1:0] acc;
        logic signed [AccW-1:0] w;
        logic [RPW-1:0]         wr;
        n_data = '0;
        for (int j = 0; j < 3; j++) begin
            acc = AccW'(r_p[j][0]) + AccW'(r_p[j][1]) + AccW'(r_p[j][2]);
            w = ((acc + AccW'(32768)) >>> 16) + AccW'(offs[j]);
            if (w > AccW'(8388607)) begin
                n_data[j*CenterW +: CenterW] = CenterW'(8388607);
            end else if (w < -AccW'(8388608)) begin
                n_data[j*CenterW +: CenterW] = CenterW'(-8388608);
            end else begin
                n_data[j*CenterW +: CenterW] = CenterW'(w);
            end
        end
        wr = (r_rp + RPW'(32768)) >> 16;
        if (r_rigid) begin
            n_data[3*CenterW +: OutRadW] = OutRadW'(r_r);
        end else if (wr > RPW'(16777215)) begin
            n_data[3*CenterW +: OutRadW] = OutRadW'(16777215);
        end else begin
            n_data[3*CenterW +: OutRadW] = OutRadW'(wr);
        end
    end
endmodule

// ----- hdl/msw_scale.sv -----
// Radius scale unit: largest squared row length, then a bit-pair square root.
// Depends on msw_pkg.
module msw_scale import msw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RowW-1:0]   i_right,
    input  logic [RowW-1:0]   i_up,
    input  logic [RowW-1:0]   i_at,
    output logic              o_busy,
    output logic [ScaleW-1:0] o_scale
);
    localparam int unsigned VW = 42;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LEN  = 3'b010,
        S_ROOT = 3'b100
    } t_state;

    t_state               r_state;
    logic [1:0]           r_row, r_elem;
    logic [VW-1:0]        r_sum, r_max, r_v, r_res, r_bit;
    logic [4:0]           r_cnt;
    logic [ScaleW-1:0]    r_scale;
    logic [RowW-1:0]      rows [3];
    logic signed [RowElemW-1:0] el;
    logic [VW-1:0]        sq, tot, trial;

    assign rows[0] = i_right;
    assign rows[1] = i_up;
    assign rows[2] = i_at;
    assign el = rows[r_row][r_elem*RowElemW +: RowElemW];
    assign sq = VW'(el * el);
    assign tot = r_sum + sq;
    assign trial = r_res + r_bit;
    assign o_busy = (r_state != S_IDLE);
    assign o_scale = r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scale <= ScaleUnity;
            r_row <= '0;
            r_elem <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_LEN;
                        r_row <= '0;
                        r_elem <= '0;
                        r_sum <= '0;
                        r_max <= '0;
                    end
                end
                S_LEN: begin
                    if (r_elem == 2'd2) begin
                        r_elem <= '0;
                        r_sum <= '0;
                        if (tot > r_max) r_max <= tot;
                        if (r_row == 2'd2) begin
                            r_state <= S_ROOT;
                            r_v <= (tot > r_max) ? tot : r_max;
                            r_res <= '0;
                            r_bit <= VW'(1) << 40;
                            r_cnt <= 5'd20;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_elem <= r_elem + 2'd1;
                        r_sum <= tot;
                    end
                end
                S_ROOT: begin
                    if (r_v >= trial) begin
                        r_v <= r_v - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_IDLE;
                        r_scale <= ScaleW'((r_v >= trial) ? ((r_res >> 1) + r_bit)
                                                          : (r_res >> 1));
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/morph_sphere_world_bound.sv -----
// Top level of the morphing world bounding sphere block: configuration registers,
// blend pipeline, transform pipeline and radius scale unit. Depends on msw_pkg.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: start x,y,z,radius, end x,y,z,radius, blend; tuser: interpolate
//  m_axis    out        tdata: world x,y,z,radius
//  cfg       in         index (register number) and data
//
// Four register stages (two for blending, two for the transform). One item
// enters per cycle while s_axis_tready is high; each stage advances on its
// own, so a held output stalls only the stages behind a full one. Reset is
// synchronous, active low, and empties the pipeline. A write to a matrix row
// starts the scale unit (nine squares, then 21 square root steps);
// s_axis_tready and o_cfg_ready stay low until it finishes.
module morph_sphere_world_bound import msw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_x, start_y, start_z, start_radius, end_x, end_y, end_z, end_radius, blend
    input  logic [InDataW-1:0]  s_axis_tdata,
    // interpolate
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // world_x, world_y, world_z, world_radius
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [RowW-1:0]     i_cfg_data
);
    t_frame        frame;
    logic [RowW-1:0] r_right, r_up, r_at;
    logic signed [CenterW-1:0] r_off_x, r_off_y, r_off_z;
    logic          r_rigid;
    logic          cfg_wr, scale_start, scale_busy;
    logic [ScaleW-1:0] scale;
    t_sphere_in    in_item;
    t_local_sphere mid_item;
    logic          blend_ready, mid_valid, mid_ready;

    // Writes wait while the scale unit reads the rows.
    assign o_cfg_ready = !scale_busy;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= RowW'(65536);
            r_up    <= RowW'(65536) << RowElemW;
            r_at    <= RowW'(65536) << (2 * RowElemW);
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
            r_rigid <= 1'b1;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ROW_RIGHT: r_right <= i_cfg_data;
                REG_ROW_UP:    r_up <= i_cfg_data;
                REG_ROW_AT:    r_at <= i_cfg_data;
                REG_OFFSET_X:  r_off_x <= i_cfg_data[CenterW-1:0];
                REG_OFFSET_Y:  r_off_y <= i_cfg_data[CenterW-1:0];
                REG_OFFSET_Z:  r_off_z <= i_cfg_data[CenterW-1:0];
                REG_RIGID:     r_rigid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Only a change of a row changes the radius scale.
    assign scale_start = cfg_wr && (t_reg_idx'(i_cfg_index) == REG_ROW_RIGHT ||
                                    t_reg_idx'(i_cfg_index) == REG_ROW_UP ||
                                    t_reg_idx'(i_cfg_index) == REG_ROW_AT);

    msw_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scale_start),
        .i_right (r_right),
        .i_up    (r_up),
        .i_at    (r_at),
        .o_busy  (scale_busy),
        .o_scale (scale)
    );

    assign frame = '{right: r_right, up: r_up, at: r_at, off_x: r_off_x, off_y: r_off_y,
                     off_z: r_off_z, rigid: r_rigid, scale: scale};

    assign in_item.sx = s_axis_tdata[23:0];
    assign in_item.sy = s_axis_tdata[47:24];
    assign in_item.sz = s_axis_tdata[71:48];
    assign in_item.sr = s_axis_tdata[94:72];
    assign in_item.ex = s_axis_tdata[118:95];
    assign in_item.ey = s_axis_tdata[142:119];
    assign in_item.ez = s_axis_tdata[166:143];
    assign in_item.er = s_axis_tdata[189:167];
    assign in_item.blend = s_axis_tdata[206:190];
    assign in_item.interp = s_axis_tuser;

    // Items are held off while the scale unit recomputes.
    assign s_axis_tready = blend_ready && !scale_busy;

    msw_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid && !scale_busy),
        .o_ready (blend_ready),
        .i_item  (in_item),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_item  (mid_item)
    );

    msw_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_item  (mid_item),
        .i_frame (frame),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );
endmodule
